/* design/tcie_pkg.sv */
// ----------------------------------------------------------------------------
// tcie_pkg
// Shared types and constants for the tagged csv integer field extractor.
// ----------------------------------------------------------------------------
package tcie_pkg;

  localparam int unsigned MaxTagLen = 8;
  localparam int unsigned TagBytesW = 64;
  localparam int unsigned TagLenW   = 4;
  localparam int unsigned FieldNumW = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgTagBytes    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTagLength   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFieldNumber = 2'd2;

  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;

  localparam logic [2:0] PhSeek   = 3'd0;
  localparam logic [2:0] PhStart  = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhNumber = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  localparam logic [1:0] NpWs     = 2'd0;
  localparam logic [1:0] NpDigits = 2'd1;
  localparam logic [1:0] NpEnd    = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] field_value;
    logic                     found;
  } out_item_t;

  // one character step handed from the input register to the datapath
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] char_code;
  } step_t;

endpackage

/* design/tcie_tag_window.sv */
// ----------------------------------------------------------------------------
// tcie_tag_window
// Sliding window of recent characters and tag compare on the updated window.
// ----------------------------------------------------------------------------
module tcie_tag_window #(
  parameter int unsigned MAX_TAG_LEN = tcie_pkg::MaxTagLen,
  localparam int unsigned LenW = $clog2(MAX_TAG_LEN + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcie_pkg::step_t                step_i,
  input  logic                           seek_i,
  input  logic [tcie_pkg::TagBytesW-1:0] tag_bytes_i,
  input  logic [LenW-1:0]                tag_len_i,
  output logic                           match_o
);

  logic [7:0]      win_q [MAX_TAG_LEN];
  logic [7:0]      win_d [MAX_TAG_LEN];
  logic [LenW-1:0] seen_q;
  logic [LenW-1:0] seen_d;
  logic            mismatch;

  always_comb begin
    win_d[0] = step_i.char_code;
    for (int j = 1; j < MAX_TAG_LEN; j++) begin
      win_d[j] = win_q[j-1];
    end
    if (seen_q < LenW'(MAX_TAG_LEN)) begin
      seen_d = seen_q + LenW'(1);
    end else begin
      seen_d = seen_q;
    end
  end

  // tag char k sits at window slot len-1-k
  always_comb begin
    mismatch = 1'b0;
    for (int k = 0; k < MAX_TAG_LEN; k++) begin
      for (int j = 0; j < MAX_TAG_LEN; j++) begin
        if ((k < int'(tag_len_i)) && (j + k + 1 == int'(tag_len_i)) &&
            (win_d[j] != tag_bytes_i[8*k +: 8])) begin
          mismatch = 1'b1;
        end
      end
    end
    match_o = (seen_d >= tag_len_i) && !mismatch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_TAG_LEN; j++) begin
        win_q[j] <= 8'd0;
      end
      seen_q <= '0;
    end else if (step_i.valid) begin
      if (step_i.last) begin
        for (int j = 0; j < MAX_TAG_LEN; j++) begin
          win_q[j] <= 8'd0;
        end
        seen_q <= '0;
      end else if (seek_i) begin
        win_q  <= win_d;
        seen_q <= seen_d;
      end
    end
  end

endmodule

/* design/tcie_field_scan.sv */
// ----------------------------------------------------------------------------
// tcie_field_scan
// Field splitter, field counter and atoi accumulator for one line.
// ----------------------------------------------------------------------------
module tcie_field_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcie_pkg::step_t                step_i,
  input  logic                           tag_match_i,
  input  logic                           tag_empty_i,
  input  logic [tcie_pkg::FieldNumW-1:0] field_number_i,
  output logic                           seek_o,
  output tcie_pkg::out_item_t            result_o
);

  localparam int unsigned VW = tcie_pkg::ValueW;
  localparam int unsigned CW = tcie_pkg::FieldNumW;

  typedef struct packed {
    logic [1:0]    phase;
    logic [VW-1:0] acc;
    logic          neg;
  } num_t;

  function automatic num_t num_feed(num_t s, logic [7:0] c);
    num_t          r;
    logic          dig;
    logic [VW-1:0] dv;
    logic [VW-1:0] acc10;
    r     = s;
    dig   = (c >= tcie_pkg::CharZero) && (c <= tcie_pkg::CharNine);
    dv    = VW'(c - tcie_pkg::CharZero);
    acc10 = (s.acc << 3) + (s.acc << 1) + dv;
    if (s.phase == tcie_pkg::NpWs) begin
      if ((c == tcie_pkg::CharSpace) ||
          ((c >= tcie_pkg::CharTab) && (c <= tcie_pkg::CharCr))) begin
        r = s;
      end else if ((c == tcie_pkg::CharPlus) || (c == tcie_pkg::CharMinus)) begin
        r.neg   = (c == tcie_pkg::CharMinus);
        r.phase = tcie_pkg::NpDigits;
      end else if (dig) begin
        r.acc   = acc10;
        r.phase = tcie_pkg::NpDigits;
      end else begin
        r.phase = tcie_pkg::NpEnd;
      end
    end else if (s.phase == tcie_pkg::NpDigits) begin
      if (dig) begin
        r.acc = acc10;
      end else begin
        r.phase = tcie_pkg::NpEnd;
      end
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] num_value(num_t s);
    return s.neg ? (VW'(0) - s.acc) : s.acc;
  endfunction

  logic [2:0]    phase_q, phase_d, phase_eff;
  logic [CW-1:0] count_q, count_d;
  num_t          num_q, num_d, num_fresh;
  logic          tail_q, tail_d;
  logic          found_q, found_d;
  logic [VW-1:0] answer_q, answer_d;
  logic [7:0]    c;
  logic          next_is_req;
  logic          end_is_req;
  logic          fin_found;
  logic [VW-1:0] fin_value;

  assign c      = step_i.char_code;
  assign seek_o = (phase_q == tcie_pkg::PhSeek) && !tag_empty_i;

  always_comb begin
    phase_eff = phase_q;
    if ((phase_q == tcie_pkg::PhSeek) && tag_empty_i) begin
      phase_eff = tcie_pkg::PhStart;
    end
    phase_d  = phase_eff;
    count_d  = count_q;
    num_d    = num_q;
    tail_d   = tail_q;
    found_d  = found_q;
    answer_d = answer_q;
    next_is_req = ({1'b0, count_q} + (CW+1)'(1)) == {1'b0, field_number_i};
    num_fresh = '{phase: tcie_pkg::NpWs, acc: '0, neg: 1'b0};

    unique case (phase_eff)
      tcie_pkg::PhSeek: begin
        if (tag_match_i) begin
          phase_d = tcie_pkg::PhStart;
        end
      end
      tcie_pkg::PhStart: begin
        if (c == tcie_pkg::CharSpace) begin
          tail_d = 1'b1;
        end else if (c == tcie_pkg::CharComma) begin
          tail_d = 1'b0;
        end else if (c == tcie_pkg::CharQuote) begin
          tail_d  = 1'b1;
          phase_d = tcie_pkg::PhSkip;
        end else begin
          tail_d = 1'b1;
          if (next_is_req) begin
            phase_d = tcie_pkg::PhNumber;
            num_d   = num_feed(num_fresh, c);
          end else begin
            phase_d = tcie_pkg::PhSkip;
          end
          if (count_q != '1) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      tcie_pkg::PhSkip: begin
        if (c == tcie_pkg::CharComma) begin
          phase_d = tcie_pkg::PhStart;
          tail_d  = 1'b0;
        end
      end
      tcie_pkg::PhNumber: begin
        if (c == tcie_pkg::CharComma) begin
          found_d  = 1'b1;
          answer_d = num_value(num_q);
          phase_d  = tcie_pkg::PhDone;
        end else begin
          num_d = num_feed(num_q, c);
        end
      end
      default: begin
      end
    endcase

    // line end: an open number or a nonempty unterminated tail closes the field
    end_is_req = ({1'b0, count_d} + (CW+1)'(1)) == {1'b0, field_number_i};
    fin_found  = found_d;
    fin_value  = answer_d;
    if (phase_d == tcie_pkg::PhNumber) begin
      fin_found = 1'b1;
      fin_value = num_value(num_d);
    end else if ((phase_d == tcie_pkg::PhStart) && tail_d && end_is_req) begin
      fin_found = 1'b1;
      fin_value = '0;
    end
    result_o.found       = fin_found;
    result_o.field_value = fin_found ? fin_value : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tcie_pkg::PhSeek;
      count_q  <= '0;
      num_q    <= '{phase: tcie_pkg::NpWs, acc: '0, neg: 1'b0};
      tail_q   <= 1'b0;
      found_q  <= 1'b0;
      answer_q <= '1;
    end else if (step_i.valid) begin
      if (step_i.last) begin
        phase_q  <= tcie_pkg::PhSeek;
        count_q  <= '0;
        num_q    <= '{phase: tcie_pkg::NpWs, acc: '0, neg: 1'b0};
        tail_q   <= 1'b0;
        found_q  <= 1'b0;
        answer_q <= '1;
      end else begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        num_q    <= num_d;
        tail_q   <= tail_d;
        found_q  <= found_d;
        answer_q <= answer_d;
      end
    end
  end

endmodule

/* design/tagged_csv_integer_field_extractor.sv */
// a last item passes the input register, then the result register, before result valid
// throughput: one character item per cycle while no last item waits on the output; the
// field scan and multiply-by-ten accumulate are combinational between input and result register
// a result item is produced only for the character flagged as last
// a last item waits in the input register while the previous result is unaccepted
// reset: async active low; clears line state, tag config to empty, field number to 1
// ----------------------------------------------------------------------------
// tagged_csv_integer_field_extractor
// Finds a configured tag in a response line and returns the requested
// comma-separated integer field after it.
// ----------------------------------------------------------------------------
module tagged_csv_integer_field_extractor #(
  parameter int unsigned MAX_TAG_LEN = tcie_pkg::MaxTagLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tcie_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tcie_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcie_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tcie_pkg::TagBytesW-1:0] cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_TAG_LEN + 1);

  logic [tcie_pkg::TagBytesW-1:0] tag_bytes_q;
  logic [tcie_pkg::TagLenW-1:0]   tag_length_q;
  logic [tcie_pkg::FieldNumW-1:0] field_number_q;
  logic [LenW-1:0]                tag_len;

  logic                 in_valid_q;
  tcie_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  tcie_pkg::out_item_t  out_q;
  logic                 advance;
  tcie_pkg::step_t      step;
  tcie_pkg::out_item_t  result;
  logic                 seek;
  logic                 tag_match;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_bytes_q    <= '0;
      tag_length_q   <= '0;
      field_number_q <= tcie_pkg::FieldNumW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tcie_pkg::CfgTagBytes:    tag_bytes_q    <= cfg_data_i;
        tcie_pkg::CfgTagLength:   tag_length_q   <= cfg_data_i[tcie_pkg::TagLenW-1:0];
        tcie_pkg::CfgFieldNumber: field_number_q <= cfg_data_i[tcie_pkg::FieldNumW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (tag_length_q > tcie_pkg::TagLenW'(MAX_TAG_LEN)) begin
      tag_len = LenW'(MAX_TAG_LEN);
    end else begin
      tag_len = LenW'(tag_length_q);
    end
  end

  // non-last items never wait on the output side
  assign advance    = in_valid_q && (!in_q.is_last || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign step.valid     = advance;
  assign step.last      = in_q.is_last;
  assign step.char_code = in_q.char_code;

  tcie_tag_window #(
    .MAX_TAG_LEN(MAX_TAG_LEN)
  ) u_tag_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .seek_i     (seek),
    .tag_bytes_i(tag_bytes_q),
    .tag_len_i  (tag_len),
    .match_o    (tag_match)
  );

  tcie_field_scan u_field_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .tag_match_i   (tag_match),
    .tag_empty_i   (tag_len == '0),
    .field_number_i(field_number_q),
    .seek_o        (seek),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.is_last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
